### rtl/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and constants for the graph reachability engine.
// ----------------------------------------------------------------------------
package gre_pkg;

   localparam int unsigned MAX_AIRPORTS_DEF  = 64;
   localparam int unsigned EDGE_COPY_MAX_DEF = 15;
   localparam int unsigned INIT_NODE_COUNT   = 10;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_RESIZE = 2'd3
   } gre_op_type;

   typedef struct packed {
      gre_op_type  req_type;
      logic [6:0]  from_airport;
      logic [6:0]  to_airport;
      logic [6:0]  new_count;
   } gre_req_type;

   typedef struct packed {
      logic status;
      logic reachable;
   } gre_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_UPDATE,
      ST_POP,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH
   } gre_state_type;

endpackage

### rtl/gre_ram.sv
// ----------------------------------------------------------------------------
// gre_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gre_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/gre_seq.sv
// ----------------------------------------------------------------------------
// gre_seq
// Request sequencer: edge updates, row clearing and the depth-first walk,
// which scans one adjacency bit per cycle of the popped node's row.
// ----------------------------------------------------------------------------
module gre_seq
   import gre_pkg::*;
#(
   parameter int unsigned MAX_AIRPORTS  = MAX_AIRPORTS_DEF,
   parameter int unsigned EDGE_COPY_MAX = EDGE_COPY_MAX_DEF,
   localparam int unsigned NODE_W = $clog2(MAX_AIRPORTS),
   localparam int unsigned CNT_W  = $clog2(EDGE_COPY_MAX + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  gre_req_type             req_data,
   output logic                    req_ready,
   input  logic                    slot_free,
   output logic                    done,
   output gre_rsp_type             rsp_out,
   // adjacency bitmap, one row per source node
   output logic                    bm_we,
   output logic                    bm_re,
   output logic [NODE_W-1:0]       bm_addr,
   output logic [MAX_AIRPORTS-1:0] bm_wdata,
   input  logic [MAX_AIRPORTS-1:0] bm_rdata,
   // edge copy counts, valid only where the bitmap bit is set
   output logic                    cnt_we,
   output logic                    cnt_re,
   output logic [2*NODE_W-1:0]     cnt_addr,
   output logic [CNT_W-1:0]        cnt_wdata,
   input  logic [CNT_W-1:0]        cnt_rdata,
   // walk stack
   output logic                    stk_we,
   output logic                    stk_re,
   output logic [NODE_W-1:0]       stk_addr,
   output logic [NODE_W-1:0]       stk_wdata,
   input  logic [NODE_W-1:0]       stk_rdata
);

   localparam logic [6:0] NODE_COUNT_RST =
      7'((INIT_NODE_COUNT < MAX_AIRPORTS) ? INIT_NODE_COUNT : MAX_AIRPORTS);
   localparam logic [NODE_W-1:0] LAST_ROW = NODE_W'(MAX_AIRPORTS - 1);
   localparam logic [NODE_W:0]   STACK_DEPTH = (NODE_W+1)'(MAX_AIRPORTS);
   localparam logic [CNT_W-1:0]  COPY_MAX = CNT_W'(EDGE_COPY_MAX);

   gre_state_type            state_ff, state_in;
   gre_req_type              req_ff, req_in;
   logic [6:0]               node_count_ff, node_count_in;
   logic [NODE_W-1:0]        clr_ff, clr_in;
   logic                     clr_rsp_ff, clr_rsp_in;
   logic [MAX_AIRPORTS-1:0]  visited_ff, visited_in;
   logic [NODE_W:0]          sp_ff, sp_in;
   logic [NODE_W-1:0]        col_ff, col_in;
   logic                     status_ff, status_in;
   logic                     reach_ff, reach_in;

   logic                     from_ok, to_ok, count_ok;
   logic [NODE_W-1:0]        from_idx, to_idx, last_col;
   logic [CNT_W-1:0]         old_cnt, new_cnt;
   logic [MAX_AIRPORTS-1:0]  row_mod;
   logic                     edge_bit;

   assign from_ok  = (req_ff.from_airport != 7'd0) && (req_ff.from_airport <= node_count_ff);
   assign to_ok    = (req_ff.to_airport != 7'd0) && (req_ff.to_airport <= node_count_ff);
   assign count_ok = 32'(req_ff.new_count) <= 32'(MAX_AIRPORTS);
   assign from_idx = NODE_W'(req_ff.from_airport - 7'd1);
   assign to_idx   = NODE_W'(req_ff.to_airport - 7'd1);
   assign last_col = NODE_W'(node_count_ff - 7'd1);
   assign edge_bit = bm_rdata[col_ff];

   // stale count behind a cleared bitmap bit reads as zero
   assign old_cnt = bm_rdata[to_idx] ? cnt_rdata : '0;

   always_comb begin
      new_cnt = old_cnt;
      if (req_ff.req_type == OP_INSERT) begin
         if (old_cnt < COPY_MAX) begin
            new_cnt = old_cnt + CNT_W'(1);
         end
      end else if (old_cnt != '0) begin
         new_cnt = old_cnt - CNT_W'(1);
      end
      row_mod = bm_rdata;
      row_mod[to_idx] = (new_cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= NODE_COUNT_RST;
         clr_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         clr_ff        <= clr_in;
         clr_rsp_ff    <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      visited_ff <= visited_in;
      sp_ff      <= sp_in;
      col_ff     <= col_in;
      status_ff  <= status_in;
      reach_ff   <= reach_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      node_count_in = node_count_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      visited_in    = visited_ff;
      sp_in         = sp_ff;
      col_in        = col_ff;
      status_in     = status_ff;
      reach_in      = reach_ff;

      req_ready = 1'b0;
      done      = 1'b0;
      bm_we     = 1'b0;
      bm_re     = 1'b0;
      bm_addr   = from_idx;
      bm_wdata  = '0;
      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_addr  = {from_idx, to_idx};
      cnt_wdata = new_cnt;
      stk_we    = 1'b0;
      stk_re    = 1'b0;
      stk_addr  = sp_ff[NODE_W-1:0];
      stk_wdata = col_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            bm_we   = 1'b1;
            bm_addr = clr_ff;
            if (clr_ff == LAST_ROW) begin
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  status_in = 1'b0;
                  reach_in  = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_in = clr_ff + NODE_W'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            status_in = 1'b0;
            reach_in  = 1'b0;
            unique case (req_ff.req_type) inside
               OP_RESIZE: begin
                  if (count_ok) begin
                     node_count_in = req_ff.new_count;
                     clr_in        = '0;
                     clr_rsp_in    = 1'b1;
                     state_in      = ST_CLEAR;
                  end else begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end
               end
               OP_QUERY: begin
                  if (from_ok && to_ok) begin
                     visited_in           = '0;
                     visited_in[from_idx] = 1'b1;
                     stk_we               = 1'b1;
                     stk_addr             = '0;
                     stk_wdata            = from_idx;
                     sp_in                = (NODE_W+1)'(1);
                     state_in             = ST_POP;
                  end else begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end
               end
               OP_INSERT, OP_DELETE: begin
                  if (from_ok && to_ok) begin
                     bm_re    = 1'b1;
                     cnt_re   = 1'b1;
                     state_in = ST_UPDATE;
                  end else begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end
               end
            endcase
         end

         ST_UPDATE: begin
            cnt_we   = 1'b1;
            bm_we    = 1'b1;
            bm_wdata = row_mod;
            state_in = ST_FINISH;
         end

         ST_POP: begin
            if (sp_ff == '0) begin
               reach_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               stk_re   = 1'b1;
               stk_addr = NODE_W'(sp_ff - (NODE_W+1)'(1));
               sp_in    = sp_ff - (NODE_W+1)'(1);
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            bm_re    = 1'b1;
            bm_addr  = stk_rdata;
            col_in   = '0;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // row stays on the bitmap read port: no bitmap read while scanning
            if (edge_bit && (col_ff == to_idx)) begin
               reach_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               if (edge_bit && !visited_ff[col_ff]) begin
                  visited_in[col_ff] = 1'b1;
                  if (sp_ff < STACK_DEPTH) begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + (NODE_W+1)'(1);
                  end
               end
               if (col_ff == last_col) begin
                  state_in = ST_POP;
               end else begin
                  col_in = col_ff + NODE_W'(1);
               end
            end
         end

         ST_FINISH: begin
            done = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_out = '{status: status_ff, reachable: reach_ff};

endmodule

### rtl/graph_reachability_engine.sv
// ----------------------------------------------------------------------------
// graph_reachability_engine
// Directed multigraph store with edge insert/delete, resize and reachability.
// ----------------------------------------------------------------------------
// One request at a time; req_ready is high only while the sequencer is idle.
// Insert and delete read the row and count, modify them and write them back.
// Resize clears one bitmap row per cycle. A query walks depth first; the
// scan unit looks at one adjacency bit per cycle of the popped node's row,
// and the walk ends early once the destination is seen. After reset a
// clearing pass over every bitmap row runs before the first request is taken.
// The response word is registered, so the next request may be taken while it
// waits on rsp_ready.
// ----------------------------------------------------------------------------
module graph_reachability_engine
   import gre_pkg::*;
#(
   parameter int unsigned MAX_AIRPORTS  = MAX_AIRPORTS_DEF,
   parameter int unsigned EDGE_COPY_MAX = EDGE_COPY_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gre_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gre_rsp_type rsp_data
);

   localparam int unsigned NODE_W = $clog2(MAX_AIRPORTS);
   localparam int unsigned CNT_W  = $clog2(EDGE_COPY_MAX + 1);

   logic                    bm_we, bm_re;
   logic [NODE_W-1:0]       bm_addr;
   logic [MAX_AIRPORTS-1:0] bm_wdata, bm_rdata;
   logic                    cnt_we, cnt_re;
   logic [2*NODE_W-1:0]     cnt_addr;
   logic [CNT_W-1:0]        cnt_wdata, cnt_rdata;
   logic                    stk_we, stk_re;
   logic [NODE_W-1:0]       stk_addr, stk_wdata, stk_rdata;

   logic                    done, slot_free;
   gre_rsp_type             rsp_out;
   logic                    rsp_valid_ff;
   gre_rsp_type             rsp_data_ff;

   gre_seq #(
      .MAX_AIRPORTS  (MAX_AIRPORTS),
      .EDGE_COPY_MAX (EDGE_COPY_MAX)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .slot_free (slot_free),
      .done      (done),
      .rsp_out   (rsp_out),
      .bm_we     (bm_we),
      .bm_re     (bm_re),
      .bm_addr   (bm_addr),
      .bm_wdata  (bm_wdata),
      .bm_rdata  (bm_rdata),
      .cnt_we    (cnt_we),
      .cnt_re    (cnt_re),
      .cnt_addr  (cnt_addr),
      .cnt_wdata (cnt_wdata),
      .cnt_rdata (cnt_rdata),
      .stk_we    (stk_we),
      .stk_re    (stk_re),
      .stk_addr  (stk_addr),
      .stk_wdata (stk_wdata),
      .stk_rdata (stk_rdata)
   );

   gre_ram #(
      .WIDTH (MAX_AIRPORTS),
      .DEPTH (MAX_AIRPORTS)
   ) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .re    (bm_re),
      .addr  (bm_addr),
      .wdata (bm_wdata),
      .rdata (bm_rdata)
   );

   gre_ram #(
      .WIDTH (CNT_W),
      .DEPTH (1 << (2 * NODE_W))
   ) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .re    (cnt_re),
      .addr  (cnt_addr),
      .wdata (cnt_wdata),
      .rdata (cnt_rdata)
   );

   gre_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_AIRPORTS)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .re    (stk_re),
      .addr  (stk_addr),
      .wdata (stk_wdata),
      .rdata (stk_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && slot_free) begin
         rsp_data_ff <= rsp_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
